// ----- rtl/core/rid_pkg.sv -----
// shared types and constants for the recent-id window dedup block
`default_nettype none

package rid_pkg;

   localparam int LIST_DEPTH = 16;
   localparam int ID_W       = 18;
   localparam int TIME_W     = 32;
   localparam int WIN_W      = 16;

   localparam logic [WIN_W-1:0] WINDOW_RESET = WIN_W'(500);

   // one list entry as it moves from cell to cell
   typedef struct packed {
      logic [ID_W-1:0]   id;
      logic [TIME_W-1:0] stamp;
   } entry_type;

   // word under test, broadcast to every cell
   typedef struct packed {
      logic [ID_W-1:0]   id;
      logic [TIME_W-1:0] now;
      logic [WIN_W-1:0]  window;
   } cmd_type;

   // per-cycle control from the sequencer
   typedef struct packed {
      logic eval;    // capture per-cell compare flags
      logic insert;  // shift the live prefix back and load the front
   } ctrl_type;

   // ripple chain from the front of the list to the back
   typedef struct packed {
      logic prefix;  // every entry ahead of this cell is live
      logic found;   // a live entry ahead of this cell holds the id
   } chain_type;

endpackage

`default_nettype wire

// ----- rtl/core/rid_cell.sv -----
// one list slot: stored entry, age and id compare, chain link
`default_nettype none

module rid_cell (
   input  wire                 clock,
   input  wire                 reset,
   input  rid_pkg::ctrl_type   ctrl,
   input  rid_pkg::cmd_type    cmd,
   input  rid_pkg::entry_type  entry_prev,
   output rid_pkg::entry_type  entry_out,
   input  rid_pkg::chain_type  chain_in,
   output rid_pkg::chain_type  chain_out
);
   import rid_pkg::*;

   logic              valid_ff;
   logic              valid_in;
   entry_type         entry_ff;
   logic              alive_ff;
   logic              hit_ff;
   logic [TIME_W-1:0] age;
   logic              alive_now;

   // age wraps modulo 2^32, so a time going backwards reads as very old
   assign age       = cmd.now - entry_ff.stamp;
   assign alive_now = valid_ff && (age <= {{(TIME_W-WIN_W){1'b0}}, cmd.window});

   always_ff @(posedge clock) begin
      if (ctrl.eval) begin
         alive_ff <= alive_now;
         hit_ff   <= alive_now && (entry_ff.id == cmd.id);
      end
   end

   // a cell keeps an entry only if all entries ahead of it were live
   assign valid_in = ctrl.insert ? chain_in.prefix : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.insert && chain_in.prefix) begin
         entry_ff <= entry_prev;
      end
   end

   assign entry_out        = entry_ff;
   assign chain_out.prefix = chain_in.prefix && alive_ff;
   assign chain_out.found  = chain_in.found || (chain_in.prefix && hit_ff);

endmodule

`default_nettype wire

// ----- rtl/core/recent_id_window_dedup.sv -----
// top level: sequencer, window register and the row of list cells
//
//  channel   ports                          handshake
//  --------  -----------------------------  ----------------------------------
//  request   req_msg_id, req_now_ms         start high while busy low
//  response  rsp_forward                    rsp_strobe high for one cycle
//  config    csr_wr_data                    csr_wr_en high, no wait
//
// after the accepting edge every cell compares age and id in ST_EVAL, then
// in ST_COMMIT the chain resolves the live prefix and the list shifts; the
// sequencer holds busy high through both states and registers the strobe as
// it leaves ST_COMMIT, so the next word can be taken at the edge that ends
// the strobe, not before. the response cannot be stalled.
// reset clears the valid bits of all cells and sets window_ms to 500.
`default_nettype none

module recent_id_window_dedup (
   input  wire                         clock,
   input  wire                         reset,
   input  wire                         start,
   output logic                        busy,
   input  wire  [rid_pkg::ID_W-1:0]    req_msg_id,
   input  wire  [rid_pkg::TIME_W-1:0]  req_now_ms,
   output logic                        rsp_strobe,
   output logic                        rsp_forward,
   input  wire                         csr_wr_en,
   input  wire  [rid_pkg::WIN_W-1:0]   csr_wr_data
);
   import rid_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EVAL,
      ST_COMMIT
   } state_type;

   state_type         state_ff;
   logic              busy_ff;
   logic              rsp_strobe_ff;
   logic              rsp_forward_ff;

   logic [ID_W-1:0]   id_ff;
   logic [TIME_W-1:0] now_ff;
   logic [WIN_W-1:0]  window_ff;

   cmd_type           cmd;
   ctrl_type          ctrl;
   entry_type         entry_new;
   entry_type         entry_cell [LIST_DEPTH];
   chain_type         chain      [LIST_DEPTH+1];
   logic              accept;
   logic              forward;

   assign accept = start && !busy_ff;

   // latch the word under test; held steady while the cells work on it
   always_ff @(posedge clock) begin
      if (accept) begin
         id_ff  <= req_msg_id;
         now_ff <= req_now_ms;
      end
   end

   // window register, written whenever csr_wr_en is high
   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff <= WINDOW_RESET;
      end else if (csr_wr_en) begin
         window_ff <= csr_wr_data;
      end
   end

   // no live match anywhere in the prefix means send and record
   assign forward = !chain[LIST_DEPTH].found;

   // sequencer with registered busy and response
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         busy_ff        <= 1'b0;
         rsp_strobe_ff  <= 1'b0;
         rsp_forward_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= 1'b0;
         unique case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  state_ff <= ST_EVAL;
                  busy_ff  <= 1'b1;
               end
            end
            ST_EVAL: begin
               state_ff <= ST_COMMIT;
            end
            ST_COMMIT: begin
               state_ff       <= ST_IDLE;
               busy_ff        <= 1'b0;
               rsp_strobe_ff  <= 1'b1;
               rsp_forward_ff <= forward;
            end
            default: begin
               state_ff <= ST_IDLE;
               busy_ff  <= 1'b0;
            end
         endcase
      end
   end

   assign cmd.id     = id_ff;
   assign cmd.now    = now_ff;
   assign cmd.window = window_ff;

   assign ctrl.eval   = (state_ff == ST_EVAL);
   // suppressed words leave the list untouched
   assign ctrl.insert = (state_ff == ST_COMMIT) && forward;

   assign entry_new.id    = id_ff;
   assign entry_new.stamp = now_ff;

   // front of the chain: nothing ahead, so the prefix is live and empty
   assign chain[0].prefix = 1'b1;
   assign chain[0].found  = 1'b0;

   // cell 0 loads the new entry, every other cell takes its neighbor's entry;
   // the first expired entry and all behind it drop out, and a full list
   // loses its oldest entry off the back
   for (genvar i = 0; i < LIST_DEPTH; i++) begin : g_cell
      if (i == 0) begin : g_front
         rid_cell u_cell (
            .clock      (clock),
            .reset      (reset),
            .ctrl       (ctrl),
            .cmd        (cmd),
            .entry_prev (entry_new),
            .entry_out  (entry_cell[i]),
            .chain_in   (chain[i]),
            .chain_out  (chain[i+1])
         );
      end else begin : g_rest
         rid_cell u_cell (
            .clock      (clock),
            .reset      (reset),
            .ctrl       (ctrl),
            .cmd        (cmd),
            .entry_prev (entry_cell[i-1]),
            .entry_out  (entry_cell[i]),
            .chain_in   (chain[i]),
            .chain_out  (chain[i+1])
         );
      end
   end

   assign busy        = busy_ff;
   assign rsp_strobe  = rsp_strobe_ff;
   assign rsp_forward = rsp_forward_ff;

endmodule

`default_nettype wire

// ----- tb/tb_recent_id_window_dedup.sv -----
// testbench for the recent-id window dedup block: directed table, then random traffic
`timescale 1ns / 1ps

module tb_recent_id_window_dedup;
   import rid_pkg::*;

   // generous cycle limit: about 1700 words, plus gaps
   localparam int CYCLE_LIMIT = 200000;
   localparam int PHASE_WORDS = 275;
   localparam int POOL_MAX    = 40;

   typedef enum logic {ROW_WORD, ROW_WINDOW} row_kind_type;

   // one line of the directed table: a word to offer or a window to program
   typedef struct {
      row_kind_type      kind;
      logic [ID_W-1:0]   id;
      logic [TIME_W-1:0] now;
      logic [WIN_W-1:0]  win;
      bit                typed;   // forward value given by hand
      bit                fwd;
   } row_type;

   // a word in flight, waiting for its response strobe
   typedef struct {
      logic [ID_W-1:0]   id;
      logic [TIME_W-1:0] now;
      bit                fwd;
   } pending_type;

   logic                clock;
   logic                reset       = 1'b1;
   logic                start       = 1'b0;
   logic [ID_W-1:0]     req_msg_id  = '0;
   logic [TIME_W-1:0]   req_now_ms  = '0;
   logic                csr_wr_en   = 1'b0;
   logic [WIN_W-1:0]    csr_wr_data = '0;
   wire                 busy;
   wire                 rsp_strobe;
   wire                 rsp_forward;

   // shadow copy of the recent-id list, newest first
   entry_type           recent_list [LIST_DEPTH];
   int                  list_fill = 0;
   logic [WIN_W-1:0]    win_ms    = WINDOW_RESET;

   pending_type         fwd_pending [$];
   row_type             directed_rows [$];
   int                  err_count   = 0;
   int                  cycle_count = 0;

   recent_id_window_dedup dut (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_msg_id  (req_msg_id),
      .req_now_ms  (req_now_ms),
      .rsp_strobe  (rsp_strobe),
      .rsp_forward (rsp_forward),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // watchdog: a hung handshake ends the run here
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   // decide forward or suppress for one word and update the shadow list
   function automatic bit dedup_predict(input logic [ID_W-1:0] id,
                                        input logic [TIME_W-1:0] now);
      int                live;
      int                i;
      bit                cut;
      logic [TIME_W-1:0] age;
      live = list_fill;
      cut  = 1'b0;
      // walk the live prefix from the front; the first expired entry ends it
      for (i = 0; i < list_fill && !cut; i++) begin
         age = now - recent_list[i].stamp;
         if (age > TIME_W'(win_ms)) begin
            live = i;
            cut  = 1'b1;
         end else if (recent_list[i].id == id) begin
            return 1'b0;
         end
      end
      // forward: expired tail gone, oldest evicted when full, new id in front
      if (live >= LIST_DEPTH)
         live = LIST_DEPTH - 1;
      for (i = live; i > 0; i--)
         recent_list[i] = recent_list[i-1];
      recent_list[0].id    = id;
      recent_list[0].stamp = now;
      list_fill = live + 1;
      return 1'b1;
   endfunction

   function automatic void add_word(input logic [ID_W-1:0] id, input logic [TIME_W-1:0] now,
                                    input bit typed, input bit fwd);
      row_type r;
      r.kind  = ROW_WORD;
      r.id    = id;
      r.now   = now;
      r.win   = '0;
      r.typed = typed;
      r.fwd   = fwd;
      directed_rows.push_back(r);
   endfunction

   function automatic void add_window(input logic [WIN_W-1:0] w);
      row_type r;
      r.kind  = ROW_WINDOW;
      r.id    = '0;
      r.now   = '0;
      r.win   = w;
      r.typed = 1'b0;
      r.fwd   = 1'b0;
      directed_rows.push_back(r);
   endfunction

   // hold start with the word until an edge sees busy low, then log the expectation
   task automatic offer_word(input logic [ID_W-1:0] id, input logic [TIME_W-1:0] now,
                             input bit typed, input bit fwd);
      pending_type p;
      bit          pred;
      start      <= 1'b1;
      req_msg_id <= id;
      req_now_ms <= now;
      do @(posedge clock); while (busy);
      pred  = dedup_predict(id, now);
      p.id  = id;
      p.now = now;
      p.fwd = typed ? fwd : pred;
      fwd_pending.push_back(p);
   endtask

   task automatic pause(input int n);
      start <= 1'b0;
      repeat (n) @(posedge clock);
   endtask

   // window changes only once the block has drained
   task automatic write_window(input logic [WIN_W-1:0] w);
      start <= 1'b0;
      while (fwd_pending.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= w;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      win_ms = w;
   endtask

   // response checker: every strobe must match the oldest word in flight
   always @(posedge clock) begin : check_resp
      pending_type p;
      if (!reset && rsp_strobe) begin
         if (fwd_pending.size() == 0) begin
            $display("%0t: response with no word in flight, expected none, got forward=%0b",
                     $time, rsp_forward);
            err_count++;
         end else begin
            p = fwd_pending.pop_front();
            if (rsp_forward !== p.fwd) begin
               $display("%0t: id=%h now=%h forward expected %0b got %0b",
                        $time, p.id, p.now, p.fwd, rsp_forward);
               err_count++;
            end
         end
      end
   end

   initial begin : stimulus
      logic [ID_W-1:0]   pool [POOL_MAX];
      logic [ID_W-1:0]   id;
      logic [TIME_W-1:0] stamp;
      logic [WIN_W-1:0]  w;
      int                pool_n;
      int                ph;
      int                n;
      int                i;
      int                sel;
      int                k;

      // directed table, window at its reset value of 500
      add_word(18'h0,     32'd0,          1'b1, 1'b1);  // empty list
      add_word(18'h0,     32'd500,        1'b1, 1'b0);  // age equal to window still live
      add_word(18'h0,     32'd501,        1'b1, 1'b1);  // one past the window
      add_word(18'h3FFFF, 32'hFFFF_FFFF,  1'b1, 1'b1);  // top id, top time
      add_word(18'h3FFFF, 32'd499,        1'b1, 1'b0);  // age of 500 across the wrap
      add_word(18'h7,     32'd1000,       1'b1, 1'b1);
      add_word(18'h9,     32'd1200,       1'b1, 1'b1);
      // time steps back: the newer front entry expires and hides the live id 7
      add_word(18'h7,     32'd1100,       1'b1, 1'b1);
      // window of zero: only the same time suppresses
      add_window(16'd0);
      add_word(18'h7,     32'd1100,       1'b1, 1'b0);
      add_word(18'h7,     32'd1101,       1'b1, 1'b1);
      // widest window: fill the list so that id 7 is evicted, then offer it again
      add_window(16'hFFFF);
      for (i = 0; i < LIST_DEPTH; i++)
         add_word(18'h20000 | ID_W'(i * 'h111), 32'd2000, 1'b0, 1'b0);
      add_word(18'h7,     32'd2000,       1'b1, 1'b1);

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[r]) begin
         if (directed_rows[r].kind == ROW_WINDOW) begin
            write_window(directed_rows[r].win);
         end else begin
            offer_word(directed_rows[r].id, directed_rows[r].now,
                       directed_rows[r].typed, directed_rows[r].fwd);
            if ($urandom_range(0, 99) < 35)
               pause($urandom_range(1, 6));
         end
      end

      // random phases: ids from a small pool, time creeping forward, some noise
      k = 0;
      for (ph = 0; ph < 6; ph++) begin
         case (ph)
            0:       w = '0;
            1:       w = '1;
            2:       w = WIN_W'(1);
            3:       w = WIN_W'($urandom_range(0, 65535));
            4:       w = WIN_W'($urandom_range(2, 3000));
            default: w = WINDOW_RESET;
         endcase
         write_window(w);
         pool_n = $urandom_range(4, POOL_MAX);
         for (i = 0; i < pool_n; i++)
            pool[i] = ID_W'($urandom_range(0, 18'h3FFFF));
         stamp = $urandom();
         for (n = 0; n < PHASE_WORDS; n++) begin
            // mostly repeats from the pool, now and then any id
            if ($urandom_range(0, 99) < 90)
               id = pool[$urandom_range(0, pool_n - 1)];
            else
               id = ID_W'($urandom());
            sel = $urandom_range(0, 99);
            if (sel < 35)
               stamp = stamp;                                             // same ms
            else if (sel < 70)
               stamp = stamp + $urandom_range(0, win_ms / 6 + 2);         // inside window
            else if (sel < 85)
               stamp = stamp + $urandom_range(win_ms / 6, win_ms + win_ms / 4 + 2);
            else if (sel < 90)
               stamp = stamp - $urandom_range(1, 100);                    // time steps back
            else if (sel < 95)
               stamp = stamp + $urandom_range(0, 1 << 20);                // long silence
            else
               stamp = $urandom();                                        // anywhere
            offer_word(id, stamp, 1'b0, 1'b0);
            // sender gaps, except for one long back-to-back stretch
            if ((k < 600 || k >= 900) && $urandom_range(0, 99) < 35)
               pause($urandom_range(1, 6));
            k++;
         end
      end

      start <= 1'b0;
      while (fwd_pending.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (err_count == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule

// ----- recent_id_window_dedup.f -----
rtl/core/rid_pkg.sv
rtl/core/rid_cell.sv
rtl/core/recent_id_window_dedup.sv
tb/tb_recent_id_window_dedup.sv
